// File: sv/dpwe_pkg.sv
// ----------------------------------------------------------------------------
// dpwe_pkg
// Shared types and constants of the dual PWM drive with encoder counting.
// ----------------------------------------------------------------------------
package dpwe_pkg;

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_BRAKE = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PERIOD  = 2'd0,
    REG_DUTY_L  = 2'd1,
    REG_DUTY_R  = 2'd2,
    REG_FORWARD = 2'd3
  } reg_idx_t;

  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned DUTY_W       = 8;
  localparam int unsigned DUTY_CLAMP_W = 7;
  // period * clamped duty, and (phase + 1) * 100, both fit in 23 bits
  localparam int unsigned PROD_W       = 23;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned HEAD_W       = 2;

  localparam logic [PERIOD_W-1:0]     PERIOD_RESET = 16'd1000;
  localparam logic [DUTY_CLAMP_W-1:0] DUTY_FULL    = 7'd100;

  // Heading codes
  localparam logic [HEAD_W-1:0] HEAD_NONE = 2'b00;
  localparam logic [HEAD_W-1:0] HEAD_FWD  = 2'b01;
  localparam logic [HEAD_W-1:0] HEAD_REV  = 2'b11;

  // Settings seen by the drive logic
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PROD_W-1:0]   prod_l;   // period * min(duty_left, 100)
    logic [PROD_W-1:0]   prod_r;   // period * min(duty_right, 100)
    logic                forward;
  } cfg_t;

  // Pin levels after an item
  typedef struct packed {
    logic pwm1;
    logic pwm2;
    logic brake;
    logic dir;
    logic busy;
  } drv_t;

  // One encoder's counts after an item
  typedef struct packed {
    logic [CNT_W-1:0]        pulses;
    logic signed [CNT_W-1:0] position;
    logic [HEAD_W-1:0]       heading;
  } enc_t;

  // Clamp a duty percent to 100
  function automatic logic [DUTY_CLAMP_W-1:0] duty_clamp(input logic [DUTY_W-1:0] duty);
    logic [DUTY_CLAMP_W-1:0] d;
    d = (duty > DUTY_W'(DUTY_FULL)) ? DUTY_FULL : duty[DUTY_CLAMP_W-1:0];
    return d;
  endfunction

endpackage

// File: sv/dual_pwm_drive_with_encoder_count.sv
// ----------------------------------------------------------------------------
// dual_pwm_drive_with_encoder_count
// Two-motor PWM drive with x1 quadrature encoder counting, stream interface.
// ----------------------------------------------------------------------------
// Takes one word per clock: a tick (encoder sample and PWM phase step), a
// start or a brake command, selected by in_tuser. Every accepted word gives
// exactly one result word with the pin levels and encoder counts after it.
// Throughput is one word per cycle while out_tready is high. A word passes an
// input register, then the drive and counter update into the result register.
// The result register holds a word under back-pressure while the input
// register still takes the next one. Configuration writes are always ready
// and should only be issued while no word is in flight; duty values above
// 100 act as 100.
// ----------------------------------------------------------------------------
module dual_pwm_drive_with_encoder_count (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // run_periods[31:0], enc1_a, enc1_b, enc2_a, enc2_b, pad
  input  logic [1:0]   in_tuser,   // cmd
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // pwm1_level, pwm2_level, brake_level, dir_level,
                                   // busy_res, pulses_one, pulses_two, pulses_avg,
                                   // position_one, position_two, heading_one,
                                   // heading_two, pad
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  dpwe_pkg::cfg_t               cfg;
  dpwe_pkg::drv_t               drv_nxt;
  dpwe_pkg::enc_t               enc1_nxt;
  dpwe_pkg::enc_t               enc2_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  logic [1:0]                   s1_cmd_r;
  logic [dpwe_pkg::CNT_W-1:0]   s1_runp_r;
  logic [3:0]                   s1_enc_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [175:0]                 out_data_r;
  logic                         in_fire;
  logic                         advance;
  logic                         sample;
  logic [dpwe_pkg::CNT_W-1:0]   sum;

  // Handshake: the input register moves on when the result register frees
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign sample    = advance && (s1_cmd_r == dpwe_pkg::CMD_TICK);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_runp_r <= in_tdata[31:0];
      s1_enc_r  <= in_tdata[35:32];
    end
  end

  dpwe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpwe_drive u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (advance),
    .cmd         (s1_cmd_r),
    .run_periods (s1_runp_r),
    .drv_nxt     (drv_nxt)
  );

  dpwe_enc u_enc1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (sample),
    .enc_a   (s1_enc_r[0]),
    .enc_b   (s1_enc_r[1]),
    .enc_nxt (enc1_nxt)
  );

  dpwe_enc u_enc2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .sample  (sample),
    .enc_a   (s1_enc_r[2]),
    .enc_b   (s1_enc_r[3]),
    .enc_nxt (enc2_nxt)
  );

  // Wrapped sum of both counts, halved
  assign sum = enc1_nxt.pulses + enc2_nxt.pulses;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {7'b0,
                     enc2_nxt.heading, enc1_nxt.heading,
                     enc2_nxt.position, enc1_nxt.position,
                     {1'b0, sum[dpwe_pkg::CNT_W-1:1]},
                     enc2_nxt.pulses, enc1_nxt.pulses,
                     drv_nxt.busy, drv_nxt.dir, drv_nxt.brake,
                     drv_nxt.pwm2, drv_nxt.pwm1};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A word that moves on always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced word lost");

endmodule

// File: sv/dpwe_cfg.sv
// ----------------------------------------------------------------------------
// dpwe_cfg
// Configuration registers; keeps the on-time products ready for compare.
// ----------------------------------------------------------------------------
module dpwe_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [dpwe_pkg::PERIOD_W-1:0]    cfg_data,
  output dpwe_pkg::cfg_t                   cfg
);

  logic [dpwe_pkg::PERIOD_W-1:0]     period_r, period_nxt;
  logic [dpwe_pkg::DUTY_CLAMP_W-1:0] duty_l_r, duty_l_nxt;
  logic [dpwe_pkg::DUTY_CLAMP_W-1:0] duty_r_r, duty_r_nxt;
  logic                              fwd_r, fwd_nxt;
  logic [dpwe_pkg::PROD_W-1:0]       prod_l_r, prod_l_nxt;
  logic [dpwe_pkg::PROD_W-1:0]       prod_r_r, prod_r_nxt;
  logic                              wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Decode the write into the new register values
  always_comb begin
    period_nxt = period_r;
    duty_l_nxt = duty_l_r;
    duty_r_nxt = duty_r_r;
    fwd_nxt    = fwd_r;
    if (wr) begin
      unique case (cfg_index)
        dpwe_pkg::REG_PERIOD:  period_nxt = cfg_data;
        dpwe_pkg::REG_DUTY_L:  duty_l_nxt = dpwe_pkg::duty_clamp(cfg_data[dpwe_pkg::DUTY_W-1:0]);
        dpwe_pkg::REG_DUTY_R:  duty_r_nxt = dpwe_pkg::duty_clamp(cfg_data[dpwe_pkg::DUTY_W-1:0]);
        dpwe_pkg::REG_FORWARD: fwd_nxt    = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Refresh the on-time products from the new values
  assign prod_l_nxt = dpwe_pkg::PROD_W'(period_nxt * duty_l_nxt);
  assign prod_r_nxt = dpwe_pkg::PROD_W'(period_nxt * duty_r_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= dpwe_pkg::PERIOD_RESET;
      duty_l_r <= '0;
      duty_r_r <= '0;
      fwd_r    <= 1'b0;
      prod_l_r <= '0;
      prod_r_r <= '0;
    end else begin
      period_r <= period_nxt;
      duty_l_r <= duty_l_nxt;
      duty_r_r <= duty_r_nxt;
      fwd_r    <= fwd_nxt;
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
    end
  end

  assign cfg.period  = period_r;
  assign cfg.prod_l  = prod_l_r;
  assign cfg.prod_r  = prod_r_r;
  assign cfg.forward = fwd_r;

endmodule

// File: sv/dpwe_drive.sv
// ----------------------------------------------------------------------------
// dpwe_drive
// Run timer, PWM phase compare, brake and direction pins.
// ----------------------------------------------------------------------------
module dpwe_drive (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dpwe_pkg::cfg_t               cfg,
  input  logic                         step,
  input  logic [1:0]                   cmd,
  input  logic [dpwe_pkg::CNT_W-1:0]   run_periods,
  output dpwe_pkg::drv_t               drv_nxt
);

  logic [dpwe_pkg::PERIOD_W-1:0] phase_r, phase_nxt;
  logic [dpwe_pkg::CNT_W-1:0]    left_r, left_nxt;
  logic                          running_r, running_nxt;
  logic                          brake_r, brake_nxt;
  logic                          dir_r, dir_nxt;
  logic                          pwm1_r, pwm1_nxt;
  logic                          pwm2_r, pwm2_nxt;

  logic [dpwe_pkg::PERIOD_W:0]   phase_inc;
  logic [dpwe_pkg::PROD_W-1:0]   phase_x100;
  logic [dpwe_pkg::CNT_W-1:0]    left_dec;
  logic                          period_end;
  logic                          on_l;
  logic                          on_r;

  // phase < floor(P*d/100) is the same as 100*(phase+1) <= P*d
  assign phase_inc  = {1'b0, phase_r} + 1'b1;
  assign phase_x100 = dpwe_pkg::PROD_W'({phase_inc, 6'b0})
                    + dpwe_pkg::PROD_W'({phase_inc, 5'b0})
                    + dpwe_pkg::PROD_W'({phase_inc, 2'b0});
  assign on_l       = phase_x100 <= cfg.prod_l;
  assign on_r       = phase_x100 <= cfg.prod_r;
  assign period_end = phase_inc >= {1'b0, cfg.period};
  assign left_dec   = left_r - 1'b1;

  // Advance the run on each item
  always_comb begin
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    running_nxt = running_r;
    brake_nxt   = brake_r;
    dir_nxt     = dir_r;
    pwm1_nxt    = pwm1_r;
    pwm2_nxt    = pwm2_r;
    if (step) begin
      unique case (cmd)
        dpwe_pkg::CMD_TICK: begin
          pwm1_nxt = running_r && on_l;
          pwm2_nxt = running_r && on_r;
          if (running_r) begin
            if (period_end) begin
              phase_nxt = '0;
              left_nxt  = left_dec;
              if (left_dec == '0) begin
                running_nxt = 1'b0;
              end
            end else begin
              phase_nxt = phase_inc[dpwe_pkg::PERIOD_W-1:0];
            end
          end
        end
        dpwe_pkg::CMD_START: begin
          dir_nxt     = cfg.forward;
          brake_nxt   = 1'b0;
          left_nxt    = run_periods;
          phase_nxt   = '0;
          running_nxt = run_periods != '0;
          pwm1_nxt    = 1'b0;
          pwm2_nxt    = 1'b0;
        end
        dpwe_pkg::CMD_BRAKE: begin
          running_nxt = 1'b0;
          left_nxt    = '0;
          phase_nxt   = '0;
          brake_nxt   = 1'b1;
          pwm1_nxt    = 1'b0;
          pwm2_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      left_r    <= '0;
      running_r <= 1'b0;
      brake_r   <= 1'b1;
      dir_r     <= 1'b0;
      pwm1_r    <= 1'b0;
      pwm2_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      running_r <= running_nxt;
      brake_r   <= brake_nxt;
      dir_r     <= dir_nxt;
      pwm1_r    <= pwm1_nxt;
      pwm2_r    <= pwm2_nxt;
    end
  end

  assign drv_nxt.pwm1  = pwm1_nxt;
  assign drv_nxt.pwm2  = pwm2_nxt;
  assign drv_nxt.brake = brake_nxt;
  assign drv_nxt.dir   = dir_nxt;
  assign drv_nxt.busy  = running_nxt;

  // A run always has periods left, never with the brake set
  a_run_has_periods: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> left_r != '0)
    else $error("run active with no periods left");

  a_brake_stops_run: assert property (@(posedge clk) disable iff (!rst_n)
    brake_r |-> !running_r)
    else $error("run active while brake engaged");

  // Phase rests at zero whenever no run is active
  a_phase_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> phase_r == '0)
    else $error("phase moving outside a run");

endmodule

// File: sv/dpwe_enc.sv
// ----------------------------------------------------------------------------
// dpwe_enc
// One x1 quadrature counter: pulses, position and heading on A rising edges.
// ----------------------------------------------------------------------------
module dpwe_enc (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           sample,
  input  logic           enc_a,
  input  logic           enc_b,
  output dpwe_pkg::enc_t enc_nxt
);

  logic                                 prev_r, prev_nxt;
  logic [dpwe_pkg::CNT_W-1:0]           pulses_r, pulses_nxt;
  logic [dpwe_pkg::CNT_W-1:0]           pos_r, pos_nxt;
  logic [dpwe_pkg::HEAD_W-1:0]          head_r, head_nxt;
  logic                                 rise;

  assign rise     = sample && !prev_r && enc_a;
  assign prev_nxt = sample ? enc_a : prev_r;

  // Count the edge; B low steps forward, B high steps back
  always_comb begin
    pulses_nxt = pulses_r;
    pos_nxt    = pos_r;
    head_nxt   = head_r;
    if (rise) begin
      pulses_nxt = pulses_r + 1'b1;
      if (!enc_b) begin
        pos_nxt  = pos_r + 1'b1;
        head_nxt = dpwe_pkg::HEAD_FWD;
      end else begin
        pos_nxt  = pos_r - 1'b1;
        head_nxt = dpwe_pkg::HEAD_REV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      pulses_r <= '0;
      pos_r    <= '0;
      head_r   <= dpwe_pkg::HEAD_NONE;
    end else begin
      prev_r   <= prev_nxt;
      pulses_r <= pulses_nxt;
      pos_r    <= pos_nxt;
      head_r   <= head_nxt;
    end
  end

  assign enc_nxt.pulses   = pulses_nxt;
  assign enc_nxt.position = pos_nxt;
  assign enc_nxt.heading  = head_nxt;

  // A sampled rising edge bumps the pulse count by one
  a_edge_counts: assert property (@(posedge clk) disable iff (!rst_n)
    rise |=> pulses_r == $past(pulses_r) + 1'b1)
    else $error("rising edge not counted");

endmodule

// File: bench/dual_pwm_drive_with_encoder_count_tb.sv
// ----------------------------------------------------------------------------
// dual_pwm_drive_with_encoder_count_tb
// Self-checking bench for the dual PWM drive with x1 encoder counting.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a clocked driver on the input stream. Each
// accepted word goes through a local model of the drive and counters, and
// the predicted pin word is queued. A clocked monitor on the result stream
// compares every result word field by field with the oldest prediction.
// Register settings change between phases, only once the block has drained.
// Both streams idle at random, apart from one calm window.
// ----------------------------------------------------------------------------
module dual_pwm_drive_with_encoder_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_SPARE   = 2'd3;   // unused code, must be ignored
  localparam logic [7:0] FULL_PCT    = 8'd100;
  localparam int         IDLE_PCT    = 9;
  localparam int         CALM_FROM   = 400;
  localparam int         CALM_TO     = 700;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_WORDS = 92;
  localparam int         NUM_PHASES  = 8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] periods;
    logic        a1, b1, a2, b2;
  } drive_item_t;

  typedef struct packed {
    logic        pwm1, pwm2, brake, dir, busy;
    logic [31:0] pulses1, pulses2, pulses_mean;
    logic [31:0] pos1, pos2;
    logic [1:0]  head1, head2;
  } pin_word_t;

  // DUT ports
  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata   = '0;   // run_periods[31:0], enc1_a, enc1_b, enc2_a, enc2_b, pad
  logic [1:0]   in_tuser   = '0;   // cmd
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;         // pwm1, pwm2, brake, dir, busy, pulses_one, pulses_two,
                                   // pulses_avg, position_one, position_two, heading_one,
                                   // heading_two, pad
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index  = '0;
  logic [15:0]  cfg_data   = '0;

  dual_pwm_drive_with_encoder_count i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Bench state
  drive_item_t pending_q[$];
  pin_word_t   pin_word_q[$];
  drive_item_t cur_item;
  pin_word_t   got_w, want_w;
  int          errors    = 0;
  int          cycle_cnt = 0;

  // Model copy of the registers
  logic [15:0] set_period = dpwe_pkg::PERIOD_RESET;
  logic [7:0]  duty_l     = '0;
  logic [7:0]  duty_r     = '0;
  logic        fwd_set    = 1'b0;

  // Model copy of the drive and counter state
  logic [15:0] phase_cnt   = '0;
  logic [31:0] periods_rem = '0;
  logic        run_on      = 1'b0;
  logic        brake_on    = 1'b1;
  logic        dir_on      = 1'b0;
  logic        pwm_q[2]    = '{1'b0, 1'b0};
  logic        last_a[2]   = '{1'b0, 1'b0};
  logic [31:0] pulse_cnt[2] = '{32'd0, 32'd0};
  logic [31:0] pos_cnt[2]   = '{32'd0, 32'd0};
  logic [1:0]  head_cnt[2]  = '{dpwe_pkg::HEAD_NONE, dpwe_pkg::HEAD_NONE};

  // Stimulus-side quadrature walkers
  logic [1:0]  quad_idx[2] = '{2'd0, 2'd0};
  logic        quad_up[2]  = '{1'b1, 1'b0};

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit calm_window();
    return (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);
  endfunction

  function automatic logic [7:0] pct_limit(input logic [7:0] d);
    return (d > FULL_PCT) ? FULL_PCT : d;
  endfunction

  // Count a rising A edge; B picks the step direction
  function automatic void count_edge(input int k, input logic a, input logic b);
    if (!last_a[k] && a) begin
      pulse_cnt[k] = pulse_cnt[k] + 32'd1;
      if (!b) begin
        head_cnt[k] = dpwe_pkg::HEAD_FWD;
        pos_cnt[k]  = pos_cnt[k] + 32'd1;
      end else begin
        head_cnt[k] = dpwe_pkg::HEAD_REV;
        pos_cnt[k]  = pos_cnt[k] - 32'd1;
      end
    end
    last_a[k] = a;
  endfunction

  // Advance the drive model by one word and return the pin word it leaves
  function automatic pin_word_t predict_pins(input drive_item_t it);
    pin_word_t   w;
    logic [31:0] on1, on2, sum;
    on1 = (32'(set_period) * 32'(pct_limit(duty_l))) / 32'(FULL_PCT);
    on2 = (32'(set_period) * 32'(pct_limit(duty_r))) / 32'(FULL_PCT);
    case (it.cmd)
      dpwe_pkg::CMD_TICK: begin
        pwm_q[0] = run_on && (32'(phase_cnt) < on1);
        pwm_q[1] = run_on && (32'(phase_cnt) < on2);
        count_edge(0, it.a1, it.b1);
        count_edge(1, it.a2, it.b2);
        if (run_on) begin
          if (32'(phase_cnt) + 32'd1 >= 32'(set_period)) begin
            phase_cnt   = '0;
            periods_rem = periods_rem - 32'd1;
            if (periods_rem == 32'd0) run_on = 1'b0;
          end else begin
            phase_cnt = phase_cnt + 16'd1;
          end
        end
      end
      dpwe_pkg::CMD_START: begin
        dir_on      = fwd_set;
        brake_on    = 1'b0;
        periods_rem = it.periods;
        phase_cnt   = '0;
        run_on      = (it.periods != 32'd0);
        pwm_q[0]    = 1'b0;
        pwm_q[1]    = 1'b0;
      end
      dpwe_pkg::CMD_BRAKE: begin
        run_on      = 1'b0;
        periods_rem = '0;
        phase_cnt   = '0;
        brake_on    = 1'b1;
        pwm_q[0]    = 1'b0;
        pwm_q[1]    = 1'b0;
      end
      default: ;  // spare code: hold everything
    endcase
    sum           = pulse_cnt[0] + pulse_cnt[1];
    w.pwm1        = pwm_q[0];
    w.pwm2        = pwm_q[1];
    w.brake       = brake_on;
    w.dir         = dir_on;
    w.busy        = run_on;
    w.pulses1     = pulse_cnt[0];
    w.pulses2     = pulse_cnt[1];
    w.pulses_mean = sum >> 1;
    w.pos1        = pos_cnt[0];
    w.pos2        = pos_cnt[1];
    w.head1       = head_cnt[0];
    w.head2       = head_cnt[1];
    return w;
  endfunction

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic void check_word(input pin_word_t want, input pin_word_t got);
    report_field("pwm1_level",   32'(want.pwm1),  32'(got.pwm1));
    report_field("pwm2_level",   32'(want.pwm2),  32'(got.pwm2));
    report_field("brake_level",  32'(want.brake), 32'(got.brake));
    report_field("dir_level",    32'(want.dir),   32'(got.dir));
    report_field("busy_res",     32'(want.busy),  32'(got.busy));
    report_field("pulses_one",   want.pulses1,     got.pulses1);
    report_field("pulses_two",   want.pulses2,     got.pulses2);
    report_field("pulses_avg",   want.pulses_mean, got.pulses_mean);
    report_field("position_one", want.pos1,        got.pos1);
    report_field("position_two", want.pos2,        got.pos2);
    report_field("heading_one",  32'(want.head1), 32'(got.head1));
    report_field("heading_two",  32'(want.head2), 32'(got.head2));
  endfunction

  // Pins are given as {enc1_a, enc1_b, enc2_a, enc2_b}
  function automatic drive_item_t mk(input logic [1:0] cmd, input logic [31:0] periods,
                                     input logic [3:0] pins);
    drive_item_t it;
    it.cmd     = cmd;
    it.periods = periods;
    it.a1      = pins[3];
    it.b1      = pins[2];
    it.a2      = pins[1];
    it.b2      = pins[0];
    return it;
  endfunction

  // Walk one encoder through a Gray sequence, with occasional reversal and noise
  function automatic logic [1:0] next_levels(input int k);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) quad_up[k] = ~quad_up[k];
    if (r >= 92) return 2'($urandom_range(0, 3));
    if (r < 40) quad_idx[k] = quad_up[k] ? quad_idx[k] + 2'd1 : quad_idx[k] - 2'd1;
    case (quad_idx[k])
      2'd0:    return 2'b00;  // {a, b}
      2'd1:    return 2'b10;
      2'd2:    return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  function automatic drive_item_t rand_item();
    drive_item_t it;
    logic [1:0]  e1, e2;
    int          r, rp;
    r  = $urandom_range(0, 99);
    rp = $urandom_range(0, 99);
    e1 = next_levels(0);
    e2 = next_levels(1);
    it = mk(dpwe_pkg::CMD_TICK, $urandom(), {e1, e2});
    if (r < 5) begin
      it.cmd = dpwe_pkg::CMD_START;
      if (rp < 8)       it.periods = 32'd0;
      else if (rp < 12) it.periods = $urandom();
      else if (rp < 15) it.periods = 32'hFFFF_FFFF;
      else              it.periods = 32'($urandom_range(1, 6));
      {it.a1, it.b1, it.a2, it.b2} = 4'($urandom_range(0, 15));
    end else if (r < 7) begin
      it.cmd = dpwe_pkg::CMD_BRAKE;
    end else if (r < 8) begin
      it.cmd = CMD_SPARE;
    end
    return it;
  endfunction

  // Write all four registers back to back, then drop valid
  task automatic set_regs(input logic [15:0] v0, v1, v2, v3);
    logic [15:0] vals[4];
    vals = '{v0, v1, v2, v3};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (dpwe_pkg::reg_idx_t'(r))
        dpwe_pkg::REG_PERIOD:  set_period = vals[r];
        dpwe_pkg::REG_DUTY_L:  duty_l     = vals[r][7:0];
        dpwe_pkg::REG_DUTY_R:  duty_r     = vals[r][7:0];
        dpwe_pkg::REG_FORWARD: fwd_set    = vals[r][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Hold until every word is in and every result is out, then let the pipe settle
  task automatic await_drain();
    @(negedge clk);
    while (pending_q.size() != 0 || in_tvalid || pin_word_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: predict on acceptance, then offer the next pending word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pin_word_q.push_back(predict_pins(cur_item));
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_item  = pending_q.pop_front();
          in_tdata  <= {4'b0, cur_item.b2, cur_item.a2, cur_item.b1, cur_item.a1,
                        cur_item.periods};
          in_tuser  <= cur_item.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_w.pwm1        = out_tdata[0];
        got_w.pwm2        = out_tdata[1];
        got_w.brake       = out_tdata[2];
        got_w.dir         = out_tdata[3];
        got_w.busy        = out_tdata[4];
        got_w.pulses1     = out_tdata[36:5];
        got_w.pulses2     = out_tdata[68:37];
        got_w.pulses_mean = out_tdata[100:69];
        got_w.pos1        = out_tdata[132:101];
        got_w.pos2        = out_tdata[164:133];
        got_w.head1       = out_tdata[166:165];
        got_w.head2       = out_tdata[168:167];
        if (pin_word_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result word: expected none, actual %h", $time,
                   out_tdata);
        end else begin
          want_w = pin_word_q.pop_front();
          check_word(want_w, got_w);
        end
      end
      out_tready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sequence: reset, directed words, then random phases under changing settings
  initial begin
    logic [15:0] per;
    logic [7:0]  dl, dr;
    logic        fw;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Period 4: left on for 2 ticks, right on for all 4
    set_regs(16'd4, 16'd50, 16'd100, 16'd1);
    @(negedge clk);
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1011));  // edges while stopped
    pending_q.push_back(mk(dpwe_pkg::CMD_START, 32'd2,         4'b0000));  // pins ignored
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'hFFFF_FFFF, 4'b0001));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1011));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1101));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b0110));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b0000));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1110));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1110));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b0001));  // completes the run
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b0000));  // after the run
    pending_q.push_back(mk(dpwe_pkg::CMD_START, 32'd0,         4'b1111));  // zero periods
    pending_q.push_back(mk(CMD_SPARE,           32'hFFFF_FFFF, 4'b1111));
    pending_q.push_back(mk(dpwe_pkg::CMD_START, 32'hFFFF_FFFF, 4'b0000));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1010));
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b0101));
    pending_q.push_back(mk(dpwe_pkg::CMD_START, 32'd3,         4'b0000));  // restart mid-run
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b1111));
    pending_q.push_back(mk(dpwe_pkg::CMD_BRAKE, 32'd0,         4'b0000));  // abort the run
    pending_q.push_back(mk(dpwe_pkg::CMD_TICK,  32'd0,         4'b0000));
    pending_q.push_back(mk(dpwe_pkg::CMD_START, 32'd5,         4'b0000));  // left running
    await_drain();

    // Random phases; a run may still be in progress across a settings change
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin per = 16'd1;     dl = 8'd255; dr = 8'd0;   fw = 1'b0; end
        1:       begin per = 16'd0;     dl = 8'd100; dr = 8'd100; fw = 1'b1; end
        2:       begin per = 16'd65535; dl = 8'd101; dr = 8'd1;   fw = 1'b1; end
        3:       begin per = 16'd3;     dl = 8'd33;  dr = 8'd67;  fw = 1'b0; end
        default: begin
          per = 16'($urandom_range(1, 12));
          dl  = 8'($urandom_range(0, 255));
          dr  = 8'($urandom_range(0, 255));
          fw  = 1'($urandom_range(0, 1));
        end
      endcase
      set_regs(per, {8'($urandom_range(0, 255)), dl}, {8'($urandom_range(0, 255)), dr},
               {15'($urandom_range(0, 32767)), fw});
      @(negedge clk);
      for (int i = 0; i < PHASE_WORDS; i++) pending_q.push_back(rand_item());
      await_drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dpwe_pkg.sv
sv/dpwe_cfg.sv
sv/dpwe_drive.sv
sv/dpwe_enc.sv
sv/dual_pwm_drive_with_encoder_count.sv
bench/dual_pwm_drive_with_encoder_count_tb.sv
